@@ design/ycblg_pkg.sv @@
// Shared types and constants for the YCbCr luma gain pixel core.
// Holds the Q2.14 colour coefficients, field widths and the channel result type.
// No dependencies.
package ycblg_pkg;

    // Pixel channel width and luma gain register format.
    localparam int PIX_W             = 8;
    localparam int GAIN_W            = 12;
    localparam int GAIN_FRAC         = 10;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd717;

    // Fractional bits of the intermediate values, default for the top level.
    localparam int DEFAULT_FRAC_BITS = 16;

    // Coefficients are Q2.14; forward sums need 22 bits.
    localparam int COEF_Q            = 14;
    localparam int Q14_W             = 22;

    // Forward transform, luma row.
    localparam int K_Y_R  = 4899;
    localparam int K_Y_G  = 9617;
    localparam int K_Y_B  = 1868;
    // Forward transform, blue difference row (red and green terms are subtracted).
    localparam int K_CB_R = 2764;
    localparam int K_CB_G = 5428;
    localparam int K_CB_B = 8192;
    // Forward transform, red difference row (green and blue terms are subtracted).
    localparam int K_CR_R = 8192;
    localparam int K_CR_G = 6860;
    localparam int K_CR_B = 1332;

    // Inverse transform coefficients, signed so that the products stay signed.
    localparam logic signed [15:0] K_R_CR = 16'sd22970;
    localparam logic signed [15:0] K_G_CB = 16'sd5638;
    localparam logic signed [15:0] K_G_CR = 16'sd11697;
    localparam logic signed [15:0] K_B_CB = 16'sd29029;

    // One saturated output channel and its clip flag.
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             clip;
    } t_chan_res;

endpackage

@@ design/ycblg_chan_sat.sv @@
// Truncates one fixed-point channel toward zero and saturates it to 0..255.
// Depends on ycblg_pkg for the channel result type.
module ycblg_chan_sat #(
    parameter int FRAC_BITS = ycblg_pkg::DEFAULT_FRAC_BITS,
    parameter int S_W       = 27
) (
    input  logic signed [S_W-1:0] i_value,
    output ycblg_pkg::t_chan_res  o_res
);
    import ycblg_pkg::*;

    logic w_neg;
    logic w_neg_clip;
    logic w_pos_clip;

    // A negative value in (-1, 0) truncates to zero without clipping: its floored
    // integer part is all ones and at least one fraction bit is set. Minus one
    // exactly, or anything lower, truncates to a negative integer and clips.
    assign w_neg      = i_value[S_W-1];
    assign w_neg_clip = w_neg & ~((&i_value[S_W-1:FRAC_BITS]) & (|i_value[FRAC_BITS-1:0]));
    assign w_pos_clip = ~w_neg & (|i_value[S_W-2:FRAC_BITS+PIX_W]);

    // Select the saturated value.
    always_comb begin
        if (w_neg) begin
            o_res.value = '0;
        end else if (w_pos_clip) begin
            o_res.value = '1;
        end else begin
            o_res.value = i_value[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
        o_res.clip = w_neg_clip | w_pos_clip;
    end

endmodule

@@ design/ycbcr_luma_gain_pixel_core.sv @@
// An accepted pixel gives its result strobe once it has passed the register stages below.
// Throughput: one pixel per clock out of reset; the four register stages (forward transform,
// multipliers, inverse sums, saturation) each take a new pixel every cycle.
// Reset (synchronous, active low) empties the pipeline and loads the luma gain with 717;
// busy is high and the configuration ready low during reset and until r_ready is set.
// The result has no back-pressure: it is shown for exactly one cycle.
module ycbcr_luma_gain_pixel_core #(
    parameter int FRAC_BITS = ycblg_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Pixel input transaction.
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [ycblg_pkg::PIX_W-1:0]   i_blue_in,
    input  logic [ycblg_pkg::PIX_W-1:0]   i_green_in,
    input  logic [ycblg_pkg::PIX_W-1:0]   i_red_in,
    // Result strobe and payload.
    output logic                          o_valid,
    output logic [ycblg_pkg::PIX_W-1:0]   o_blue_out,
    output logic [ycblg_pkg::PIX_W-1:0]   o_green_out,
    output logic [ycblg_pkg::PIX_W-1:0]   o_red_out,
    output logic                          o_clipped,
    // Luma gain configuration write.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ycblg_pkg::GAIN_W-1:0]  i_cfg_data
);
    import ycblg_pkg::*;

    // Scaling from Q14 to the intermediate format, and derived widths.
    localparam int UP  = (FRAC_BITS >= COEF_Q) ? (FRAC_BITS - COEF_Q) : 0;
    localparam int DN  = (FRAC_BITS >= COEF_Q) ? 0 : (COEF_Q - FRAC_BITS);
    localparam int Y_W = Q14_W + UP;
    localparam int D_W = Q14_W + UP;
    localparam int G_W = Y_W + GAIN_W;
    localparam int P_W = D_W + 16;
    localparam int S_W = D_W + 5;

    logic w_accept;
    logic r_ready;
    logic [GAIN_W-1:0] r_luma_gain;

    // Stage valid bits.
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_s3_vld;
    logic r_s4_vld;

    // Stage 1: forward transform in Q14.
    logic        [Q14_W-1:0] n_y14;
    logic signed [Q14_W-1:0] n_dcb14;
    logic signed [Q14_W-1:0] n_dcr14;
    logic        [Q14_W-1:0] r_y14;
    logic signed [Q14_W-1:0] r_dcb14;
    logic signed [Q14_W-1:0] r_dcr14;

    // Stage 2: gain and inverse products.
    logic        [Y_W-1:0] w_y;
    logic signed [D_W-1:0] w_dcb;
    logic signed [D_W-1:0] w_dcr;
    logic        [G_W-1:0] r_ys_p;
    logic signed [P_W-1:0] r_p_rcr;
    logic signed [P_W-1:0] r_p_gcb;
    logic signed [P_W-1:0] r_p_gcr;
    logic signed [P_W-1:0] r_p_bcb;

    // Stage 3: inverse sums.
    logic        [S_W-1:0] w_ys;
    logic signed [S_W-1:0] n_ro;
    logic signed [S_W-1:0] n_go;
    logic signed [S_W-1:0] n_bo;
    logic signed [S_W-1:0] r_ro;
    logic signed [S_W-1:0] r_go;
    logic signed [S_W-1:0] r_bo;

    // Stage 4: saturated channels.
    t_chan_res w_sat_b;
    t_chan_res w_sat_g;
    t_chan_res w_sat_r;
    logic [PIX_W-1:0] r_blue_out;
    logic [PIX_W-1:0] r_green_out;
    logic [PIX_W-1:0] r_red_out;
    logic             r_clipped;

    // Handshakes: the pipeline never stalls, so it is ready whenever out of reset.
    assign o_busy      = ~r_ready;
    assign o_cfg_ready = r_ready;
    assign w_accept    = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_luma_gain <= GAIN_RESET;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_luma_gain <= i_cfg_data;
            end
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // Forward transform. The 128 offsets of Cb and Cr cancel against the later
    // subtraction of one half, so only the differences are carried.
    assign n_y14   = Q14_W'(K_Y_R) * Q14_W'(i_red_in)
                   + Q14_W'(K_Y_G) * Q14_W'(i_green_in)
                   + Q14_W'(K_Y_B) * Q14_W'(i_blue_in);
    assign n_dcb14 = Q14_W'(K_CB_B) * Q14_W'(i_blue_in)
                   - Q14_W'(K_CB_R) * Q14_W'(i_red_in)
                   - Q14_W'(K_CB_G) * Q14_W'(i_green_in);
    assign n_dcr14 = Q14_W'(K_CR_R) * Q14_W'(i_red_in)
                   - Q14_W'(K_CR_G) * Q14_W'(i_green_in)
                   - Q14_W'(K_CR_B) * Q14_W'(i_blue_in);

    always_ff @(posedge i_clk) begin
        r_y14   <= n_y14;
        r_dcb14 <= n_dcb14;
        r_dcr14 <= n_dcr14;
    end

    // Bring Q14 to the intermediate format; a down shift floors.
    assign w_y   = (Y_W'(r_y14) << UP) >> DN;
    assign w_dcb = (D_W'(r_dcb14) <<< UP) >>> DN;
    assign w_dcr = (D_W'(r_dcr14) <<< UP) >>> DN;

    // Luma gain and the four inverse products.
    always_ff @(posedge i_clk) begin
        r_ys_p  <= G_W'(w_y) * G_W'(r_luma_gain);
        r_p_rcr <= P_W'(w_dcr) * P_W'(K_R_CR);
        r_p_gcb <= P_W'(w_dcb) * P_W'(K_G_CB);
        r_p_gcr <= P_W'(w_dcr) * P_W'(K_G_CR);
        r_p_bcb <= P_W'(w_dcb) * P_W'(K_B_CB);
    end

    // Inverse sums; the luma gain product is floored back from Q10, each inverse product from Q14.
    assign w_ys = S_W'(r_ys_p >> GAIN_FRAC);
    assign n_ro = w_ys + S_W'(r_p_rcr >>> COEF_Q);
    assign n_go = w_ys - S_W'(r_p_gcb >>> COEF_Q) - S_W'(r_p_gcr >>> COEF_Q);
    assign n_bo = w_ys + S_W'(r_p_bcb >>> COEF_Q);

    always_ff @(posedge i_clk) begin
        r_ro <= n_ro;
        r_go <= n_go;
        r_bo <= n_bo;
    end

    // Saturation of each channel.
    ycblg_chan_sat #(
        .FRAC_BITS (FRAC_BITS),
        .S_W       (S_W)
    ) u_sat_b (
        .i_value (r_bo),
        .o_res   (w_sat_b)
    );

    ycblg_chan_sat #(
        .FRAC_BITS (FRAC_BITS),
        .S_W       (S_W)
    ) u_sat_g (
        .i_value (r_go),
        .o_res   (w_sat_g)
    );

    ycblg_chan_sat #(
        .FRAC_BITS (FRAC_BITS),
        .S_W       (S_W)
    ) u_sat_r (
        .i_value (r_ro),
        .o_res   (w_sat_r)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        r_blue_out  <= w_sat_b.value;
        r_green_out <= w_sat_g.value;
        r_red_out   <= w_sat_r.value;
        r_clipped   <= w_sat_b.clip | w_sat_g.clip | w_sat_r.clip;
    end

    assign o_valid     = r_s4_vld;
    assign o_blue_out  = r_blue_out;
    assign o_green_out = r_green_out;
    assign o_red_out   = r_red_out;
    assign o_clipped   = r_clipped;

`ifndef ASSERT_OFF
    // Every accepted pixel gives a result strobe after it has passed through the pipeline registers.
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##3 o_valid)
        else $error("accepted pixel did not produce a result after four cycles");

    // A result strobe out of reset is always caused by an accepted input transaction.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 4)) |-> $past(w_accept, 4))
        else $error("result strobe without a matching input transaction");

    // Reset empties the pipeline and holds busy high and the configuration ready low.
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!o_valid && o_busy && !o_cfg_ready))
        else $error("pipeline or handshakes not cleared by reset");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for ycbcr_luma_gain_pixel_core: pixels in, checked pixels out.
// Predicts every result from its own fixed-point colour model and the luma gain setting.
// Depends on ycblg_pkg and the core RTL only.
module tb;
    import ycblg_pkg::*;

    localparam int FRAC           = DEFAULT_FRAC_BITS;
    localparam int COEF_SHIFT     = 14;
    localparam int LATENCY        = 4;
    localparam int TIMEOUT_CYCLES = 200000;

    // Model coefficients in Q2.14.
    localparam longint C_Y_R  = 4899;
    localparam longint C_Y_G  = 9617;
    localparam longint C_Y_B  = 1868;
    localparam longint C_CB_R = -2764;
    localparam longint C_CB_G = -5428;
    localparam longint C_CB_B = 8192;
    localparam longint C_CR_R = 8192;
    localparam longint C_CR_G = -6860;
    localparam longint C_CR_B = -1332;
    localparam longint C_R_CR = 22970;
    localparam longint C_G_CB = 5638;
    localparam longint C_G_CR = 11697;
    localparam longint C_B_CB = 29029;

    typedef struct {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             clipped;
    } t_rgb_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [PIX_W-1:0]    i_blue_in;
    logic [PIX_W-1:0]    i_green_in;
    logic [PIX_W-1:0]    i_red_in;
    logic                o_valid;
    logic [PIX_W-1:0]    o_blue_out;
    logic [PIX_W-1:0]    o_green_out;
    logic [PIX_W-1:0]    o_red_out;
    logic                o_clipped;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [GAIN_W-1:0]   i_cfg_data;

    t_rgb_result         expected_pixels[$];
    logic [GAIN_W-1:0]   gain_setting;
    int                  error_count;
    bit                  idle_on;

    ycbcr_luma_gain_pixel_core #(
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .o_valid     (o_valid),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs.
    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("simulation failed");
        $finish;
    end

    // Brings a Q14 sum to the working fraction width, rounding down.
    function automatic longint q14_to_frac(input longint v);
        if (FRAC >= COEF_SHIFT)
            return v <<< (FRAC - COEF_SHIFT);
        return v >>> (COEF_SHIFT - FRAC);
    endfunction

    // Truncates towards zero and saturates to one 8-bit channel.
    function automatic logic [PIX_W-1:0] saturate_channel(input longint v, inout logic clip);
        longint whole;
        if (v >= 0)
            whole = v >>> FRAC;
        else
            whole = -((-v) >>> FRAC);
        if (whole < 0) begin
            clip = 1'b1;
            return '0;
        end
        if (whole > 255) begin
            clip = 1'b1;
            return 8'd255;
        end
        return whole[PIX_W-1:0];
    endfunction

    // Expected output pixel for one input pixel under the given luma gain.
    function automatic t_rgb_result predict_pixel(input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] r,
                                                  input logic [GAIN_W-1:0] gain);
        longint bl, gl, rl, y, cb, cr, ys, dcb, dcr;
        longint half, ro, go, bo;
        logic clip;
        t_rgb_result res;
        bl = longint'(b);
        gl = longint'(g);
        rl = longint'(r);
        half = longint'(128) <<< FRAC;
        y  = q14_to_frac(C_Y_R * rl + C_Y_G * gl + C_Y_B * bl);
        cb = q14_to_frac(C_CB_R * rl + C_CB_G * gl + C_CB_B * bl + (longint'(128) <<< 14));
        cr = q14_to_frac(C_CR_R * rl + C_CR_G * gl + C_CR_B * bl + (longint'(128) <<< 14));
        ys = (y * longint'(gain)) >>> 10;
        dcb = cb - half;
        dcr = cr - half;
        ro = ys + ((dcr * C_R_CR) >>> COEF_SHIFT);
        go = ys - ((dcb * C_G_CB) >>> COEF_SHIFT) - ((dcr * C_G_CR) >>> COEF_SHIFT);
        bo = ys + ((dcb * C_B_CB) >>> COEF_SHIFT);
        clip = 1'b0;
        res.blue    = saturate_channel(bo, clip);
        res.green   = saturate_channel(go, clip);
        res.red     = saturate_channel(ro, clip);
        res.clipped = clip;
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Compares every result strobe with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_rgb_result exp_pix;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result strobe with no pixel outstanding");
            end else begin
                exp_pix = expected_pixels.pop_front();
                if (o_blue_out !== exp_pix.blue)
                    report_mismatch($sformatf("blue %0d, expected %0d",
                                              o_blue_out, exp_pix.blue));
                if (o_green_out !== exp_pix.green)
                    report_mismatch($sformatf("green %0d, expected %0d",
                                              o_green_out, exp_pix.green));
                if (o_red_out !== exp_pix.red)
                    report_mismatch($sformatf("red %0d, expected %0d",
                                              o_red_out, exp_pix.red));
                if (o_clipped !== exp_pix.clipped)
                    report_mismatch($sformatf("clipped %0b, expected %0b",
                                              o_clipped, exp_pix.clipped));
            end
        end
    end

    // Offers one pixel and waits until the core takes the transaction.
    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r);
        i_start    <= 1'b1;
        i_blue_in  <= b;
        i_green_in <= g;
        i_red_in   <= r;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        expected_pixels.push_back(predict_pixel(b, g, r, gain_setting));
        // Random idle cycles after the transaction, when enabled.
        if (idle_on) begin
            while ($urandom_range(0, 99) < 30) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Lowers start and waits for every outstanding result, reporting any that never arrive, then lets the pipe settle.
    task automatic wait_for_results;
        int waited;
        waited = 0;
        i_start <= 1'b0;
        while (expected_pixels.size() != 0 && waited < 20 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
            expected_pixels.delete();
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Writes the luma gain; only called while the core is idle.
    task automatic write_gain(input logic [GAIN_W-1:0] value);
        if (idle_on)
            repeat ($urandom_range(0, 2)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        gain_setting = value;
    endtask

    // Channel value biased towards the extremes.
    function automatic logic [PIX_W-1:0] random_channel;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // All eight corner colours under the reset gain, with no write beforehand.
    task automatic test_reset_gain_corners;
        int k;
        for (k = 0; k < 8; k++)
            send_pixel(k[0] ? 8'd255 : 8'd0, k[1] ? 8'd255 : 8'd0, k[2] ? 8'd255 : 8'd0);
        wait_for_results();
    endtask

    // Largest and zero gain: clipping above 255, below zero and just under zero.
    task automatic test_gain_extremes;
        write_gain(12'hFFF);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd2, 8'd3);
        wait_for_results();
        write_gain(12'd0);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd127, 8'd128, 8'd129);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_for_results();
    endtask

    // Random pixels under a sweep of gain settings, one phase per setting.
    task automatic test_random_gain_sweep;
        logic [GAIN_W-1:0] gains[9];
        int p, n;
        gains = '{12'd1024, 12'hFFF, 12'd0, 12'd717, 12'd2048, 12'd1, 12'd3500, 12'hFFE,
                  12'd512};
        for (p = 0; p < 11; p++) begin
            if (p < 9)
                write_gain(gains[p]);
            else
                write_gain(GAIN_W'($urandom_range(0, 4095)));
            for (n = 0; n < 45; n++)
                send_pixel(random_channel(), random_channel(), random_channel());
            wait_for_results();
        end
    endtask

    // A long stream with start held high and no idle cycles at all.
    task automatic test_back_to_back_stream;
        int n;
        idle_on = 1'b0;
        write_gain(GAIN_W'($urandom_range(0, 4095)));
        for (n = 0; n < 150; n++)
            send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)));
        wait_for_results();
        idle_on = 1'b1;
    endtask

    // The sender stops mid-stream until the pipeline has fully emptied.
    task automatic test_pause_until_drained;
        int n;
        write_gain(12'd1300);
        for (n = 0; n < 20; n++)
            send_pixel(random_channel(), random_channel(), random_channel());
        wait_for_results();
        for (n = 0; n < 20; n++)
            send_pixel(random_channel(), random_channel(), random_channel());
        wait_for_results();
    endtask

    // Reset, then each test in turn, then the verdict.
    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_blue_in    <= '0;
        i_green_in   <= '0;
        i_red_in     <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        gain_setting = 12'd717;
        error_count  = 0;
        idle_on      = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_gain_corners();
        test_gain_extremes();
        test_random_gain_sweep();
        test_back_to_back_stream();
        test_pause_until_drained();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
